// File: sv/snp_frame_deframer_with_sum_macros.svh
// Assertion macros for the snp frame deframer.
// Used by the top level; expects aclk and aresetn in the enclosing scope.
`ifndef SNP_FRAME_DEFRAMER_WITH_SUM_MACROS_SVH
`define SNP_FRAME_DEFRAMER_WITH_SUM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sfd_pkg.sv
// Shared types and constants for the snp frame deframer.
// No dependencies; used by sfd_run_emit and snp_frame_deframer_with_sum.
package sfd_pkg;

    localparam int MAX_PARAMS_DEF = 16;
    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 7;
    localparam int INDEX_W        = 6;

    localparam logic [BYTE_W-1:0] CH_S = 8'h73;
    localparam logic [BYTE_W-1:0] CH_N = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_P = 8'h70;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SUM_ERR = 2'd1,
        ST_NO_PKT  = 2'd2,
        ST_LEN_ERR = 2'd3
    } status_t;

    // One request from the parser to the result emitter.
    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   ftype;
        logic [COUNT_W-1:0]  count;
    } run_req_t;

endpackage

// File: sv/sfd_run_emit.sv
// Parameter store and result emitter of the snp frame deframer.
// Depends on sfd_pkg; instantiated by snp_frame_deframer_with_sum.
module sfd_run_emit #(
    parameter int MAX_PARAMS = sfd_pkg::MAX_PARAMS_DEF,
    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [sfd_pkg::BYTE_W-1:0]      wr_data,
    input  logic                            req_valid,
    input  sfd_pkg::run_req_t               req,
    output logic                            busy,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_frame_status,
    output logic [sfd_pkg::BYTE_W-1:0]      m_frame_type,
    output logic [sfd_pkg::COUNT_W-1:0]     m_param_count,
    output logic [sfd_pkg::INDEX_W-1:0]     m_param_index,
    output logic [sfd_pkg::BYTE_W-1:0]      m_param_value,
    output logic                            m_run_last
);
    import sfd_pkg::*;

    typedef enum logic {EM_IDLE, EM_LOAD} emit_state_t;

    emit_state_t          state_reg;
    run_req_t             run_reg;
    logic [COUNT_W-1:0]   idx_reg;
    logic [BYTE_W-1:0]    mem [MAX_PARAMS];
    logic [BYTE_W-1:0]    rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 out_free;
    logic                 is_last;

    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [BYTE_W-1:0]    m_type_reg;
    logic [COUNT_W-1:0]   m_count_reg;
    logic [INDEX_W-1:0]   m_index_reg;
    logic [BYTE_W-1:0]    m_value_reg;
    logic                 m_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (idx_reg + COUNT_W'(1)) == run_reg.count;
    assign busy     = (state_reg == EM_LOAD);

    // Entry 0 is read while idle so a run can start without a bubble; during a
    // run the next entry is fetched whenever the current one moves out.
    always_comb begin
        rd_addr = '0;
        if (state_reg == EM_LOAD) begin
            if (out_free) begin
                rd_addr = idx_reg[AW-1:0] + AW'(1);
            end else begin
                rd_addr = idx_reg[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                EM_IDLE: begin
                    if (req_valid && (req.count == '0)) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= req.status;
                        m_type_reg   <= req.ftype;
                        m_count_reg  <= '0;
                        m_index_reg  <= '0;
                        m_value_reg  <= '0;
                        m_last_reg   <= 1'b1;
                    end else begin
                        if (m_ready) begin
                            m_valid_reg <= 1'b0;
                        end
                        if (req_valid) begin
                            run_reg   <= req;
                            idx_reg   <= '0;
                            state_reg <= EM_LOAD;
                        end
                    end
                end
                EM_LOAD: begin
                    // When the output register is not free it holds a result
                    // that the receiver has not taken yet, so nothing changes.
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= run_reg.status;
                        m_type_reg   <= run_reg.ftype;
                        m_count_reg  <= run_reg.count;
                        m_index_reg  <= idx_reg[INDEX_W-1:0];
                        m_value_reg  <= rd_data_reg;
                        m_last_reg   <= is_last;
                        idx_reg      <= idx_reg + COUNT_W'(1);
                        if (is_last) begin
                            state_reg <= EM_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= EM_IDLE;
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_status = m_status_reg;
    assign m_frame_type   = m_type_reg;
    assign m_param_count  = m_count_reg;
    assign m_param_index  = m_index_reg;
    assign m_param_value  = m_value_reg;
    assign m_run_last     = m_last_reg;

endmodule

// File: sv/snp_frame_deframer_with_sum.sv
// Top level of the snp frame deframer; depends on sfd_pkg, sfd_run_emit and
// snp_frame_deframer_with_sum_macros.svh.
//
// The s_ channel takes one received byte per transaction, with s_chunk_end
// marking the last byte of a receive chunk. The first "snp" frame of each
// chunk is parsed: type, length, parameters and a 16-bit big-endian sum.
// The m_ channel gives the results: one per parameter (one if there are none)
// after the checksum byte, or a single status result for a bad header, an
// oversize length or a chunk that ends before its frame is complete.
// Bytes are taken at one per cycle while no run is being emitted. A single
// result is in the output register in the cycle after its byte is accepted.
// A parameter run reads the parameter memory one entry per cycle while m_ready
// stays high: the checksum byte moves the emitter to EM_LOAD, which registers the
// first result and then one per cycle, and s_ready is held low for the whole run.
// s_ready also stays low while a result waits and m_ready is low; a stalled
// receiver therefore stalls the input without losing data.
// Reset (aresetn low, synchronous) returns the parser to hunting for 's' and
// empties the output register; the memory is not cleared.
`include "snp_frame_deframer_with_sum_macros.svh"

module snp_frame_deframer_with_sum #(
    parameter int MAX_PARAMS = sfd_pkg::MAX_PARAMS_DEF,
    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]      s_rx_byte,
    input  logic                            s_chunk_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_frame_status,
    output logic [sfd_pkg::BYTE_W-1:0]      m_frame_type,
    output logic [sfd_pkg::COUNT_W-1:0]     m_param_count,
    output logic [sfd_pkg::INDEX_W-1:0]     m_param_index,
    output logic [sfd_pkg::BYTE_W-1:0]      m_param_value,
    output logic                            m_run_last
);
    import sfd_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT, PH_N, PH_P, PH_TYPE, PH_LEN, PH_PARAM, PH_CS_HI, PH_CS_LO
    } phase_t;

    phase_t               phase_reg,  phase_next;
    logic [15:0]          sum_reg,    sum_next;
    logic [BYTE_W-1:0]    type_reg,   type_next;
    logic [BYTE_W-1:0]    len_reg,    len_next;
    logic [COUNT_W-1:0]   taken_reg,  taken_next;
    logic [BYTE_W-1:0]    hi_reg,     hi_next;
    logic                 done_reg,   done_next;

    logic                 accept;
    logic                 run_busy;
    logic                 req_valid;
    run_req_t             req;
    logic                 wr_en;

    assign s_ready = !run_busy && (!m_valid || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        hi_next    = hi_reg;
        done_next  = done_reg;
        req_valid  = 1'b0;
        req        = '{status: ST_NO_PKT, ftype: '0, count: '0};
        wr_en      = 1'b0;
        if (accept) begin
            if (!done_reg) begin
                case (phase_reg)
                    PH_HUNT: begin
                        if (s_rx_byte == CH_S) begin
                            sum_next   = 16'(CH_S);
                            type_next  = '0;
                            len_next   = '0;
                            taken_next = '0;
                            phase_next = PH_N;
                        end
                    end
                    PH_N, PH_P: begin
                        if (s_rx_byte != ((phase_reg == PH_N) ? CH_N : CH_P)) begin
                            req_valid  = 1'b1;
                            done_next  = 1'b1;
                            phase_next = PH_HUNT;
                        end else begin
                            sum_next   = sum_reg + 16'(s_rx_byte);
                            phase_next = (phase_reg == PH_N) ? PH_P : PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        type_next  = s_rx_byte;
                        sum_next   = sum_reg + 16'(s_rx_byte);
                        phase_next = PH_LEN;
                    end
                    PH_LEN: begin
                        len_next = s_rx_byte;
                        sum_next = sum_reg + 16'(s_rx_byte);
                        if (s_rx_byte > BYTE_W'(MAX_PARAMS)) begin
                            req_valid  = 1'b1;
                            req.status = ST_LEN_ERR;
                            req.ftype  = type_reg;
                            done_next  = 1'b1;
                            phase_next = PH_HUNT;
                        end else begin
                            phase_next = (s_rx_byte != '0) ? PH_PARAM : PH_CS_HI;
                        end
                    end
                    PH_PARAM: begin
                        wr_en      = taken_reg < COUNT_W'(MAX_PARAMS);
                        sum_next   = sum_reg + 16'(s_rx_byte);
                        taken_next = taken_reg + COUNT_W'(1);
                        if ({1'b0, taken_next} >= len_reg) begin
                            phase_next = PH_CS_HI;
                        end
                    end
                    PH_CS_HI: begin
                        hi_next    = s_rx_byte;
                        phase_next = PH_CS_LO;
                    end
                    PH_CS_LO: begin
                        req_valid  = 1'b1;
                        req.status = ({hi_reg, s_rx_byte} == sum_reg) ? ST_OK : ST_SUM_ERR;
                        req.ftype  = type_reg;
                        // The length was checked against MAX_PARAMS, so it fits the count.
                        req.count  = len_reg[COUNT_W-1:0];
                        done_next  = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
            // A chunk that closes without having produced a result reports no packet.
            if (s_chunk_end) begin
                if (!done_next) begin
                    req_valid = 1'b1;
                    req       = '{status: ST_NO_PKT, ftype: '0, count: '0};
                end
                done_next  = 1'b0;
                phase_next = PH_HUNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            sum_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            taken_reg <= '0;
            hi_reg    <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            hi_reg    <= hi_next;
            done_reg  <= done_next;
        end
    end

    sfd_run_emit #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr_en          (wr_en),
        .wr_addr        (taken_reg[AW-1:0]),
        .wr_data        (s_rx_byte),
        .req_valid      (req_valid),
        .req            (req),
        .busy           (run_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_status (m_frame_status),
        .m_frame_type   (m_frame_type),
        .m_param_count  (m_param_count),
        .m_param_index  (m_param_index),
        .m_param_value  (m_param_value),
        .m_run_last     (m_run_last)
    );

    `SFD_ASSERT_IMP(a_no_input_during_run, run_busy, !s_ready, "byte accepted during a run")
    `SFD_ASSERT_IMP(a_req_has_room, req_valid, (!m_valid || m_ready), "result overwritten")
    `SFD_ASSERT_IMP(a_run_last_ends_run, run_busy && m_valid, !m_run_last, "last result mid run")
    `SFD_ASSERT_NXT(a_write_not_in_run, wr_en, !run_busy, "store write started a run")

endmodule
